>>> rtl/kmcq_pkg.sv
// ----------------------------------------------------------------------------
// kmcq_pkg
// Shared types and constants of the k-means colour quantiser.
// ----------------------------------------------------------------------------
package kmcq_pkg;

    localparam int COLOR_W = 24;
    localparam int DIST_W  = 29;

    localparam logic [4:0] W_RED   = 5'd30;
    localparam logic [5:0] W_GREEN = 6'd59;
    localparam logic [3:0] W_BLUE  = 4'd11;

    localparam logic [DIST_W-1:0]  MOVE_LIMIT = DIST_W'(10000);
    localparam logic [COLOR_W-1:0] WHITE      = 24'hFFFFFF;

    localparam logic [1:0] REG_NUM_COLORS = 2'd0;
    localparam logic [1:0] REG_MAX_PASSES = 2'd1;

    typedef struct packed {
        logic       last;
        logic [5:0] idx;
    } dist_tag_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS_CLR,
        ST_RD,
        ST_LATCH,
        ST_ISSUE,
        ST_WAIT,
        ST_UPD_START,
        ST_DIV,
        ST_MOVE,
        ST_MOVE_WAIT,
        ST_PASS_END,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/kmcq_ram.sv
// ----------------------------------------------------------------------------
// kmcq_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module kmcq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/kmcq_dist.sv
// ----------------------------------------------------------------------------
// kmcq_dist
// Two-stage pipelined weighted squared colour distance, with a tag.
// ----------------------------------------------------------------------------
module kmcq_dist (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [kmcq_pkg::COLOR_W-1:0] in_a,
    input  logic [kmcq_pkg::COLOR_W-1:0] in_b,
    input  kmcq_pkg::dist_tag_t       in_tag,
    output logic                      out_valid,
    output logic [kmcq_pkg::DIST_W-1:0]  out_dist,
    output kmcq_pkg::dist_tag_t       out_tag
);
    import kmcq_pkg::*;

    function automatic logic [7:0] chan_diff(input logic [7:0] x, input logic [7:0] y);
        chan_diff = (x > y) ? (x - y) : (y - x);
    endfunction

    logic        v1_reg, v2_reg;
    dist_tag_t   t1_reg, t2_reg;
    logic [12:0] r1_reg;
    logic [13:0] g1_reg;
    logic [11:0] b1_reg;
    logic [25:0] r2_reg;
    logic [27:0] g2_reg;
    logic [23:0] b2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        t1_reg <= in_tag;
        t2_reg <= t1_reg;
        r1_reg <= 13'(chan_diff(in_a[7:0], in_b[7:0]) * W_RED);
        g1_reg <= 14'(chan_diff(in_a[15:8], in_b[15:8]) * W_GREEN);
        b1_reg <= 12'(chan_diff(in_a[23:16], in_b[23:16]) * W_BLUE);
        r2_reg <= 26'(r1_reg * r1_reg);
        g2_reg <= 28'(g1_reg * g1_reg);
        b2_reg <= 24'(b1_reg * b1_reg);
    end

    assign out_valid = v2_reg;
    assign out_tag   = t2_reg;
    assign out_dist  = DIST_W'(r2_reg) + DIST_W'(g2_reg) + DIST_W'(b2_reg);
endmodule

>>> rtl/kmcq_div.sv
// ----------------------------------------------------------------------------
// kmcq_div
// Three-channel restoring divider giving an eight-bit mean per channel.
// ----------------------------------------------------------------------------
module kmcq_div #(
    parameter int CNT_W = 17
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [CNT_W+7:0]          sum_r,
    input  logic [CNT_W+7:0]          sum_g,
    input  logic [CNT_W+7:0]          sum_b,
    input  logic [CNT_W-1:0]          count,
    output logic                      done,
    output logic [kmcq_pkg::COLOR_W-1:0] mean
);
    import kmcq_pkg::*;

    localparam int SUM_W = CNT_W + 8;

    logic             busy_reg, done_reg;
    logic [2:0]       bit_reg;
    logic [SUM_W-1:0] rem_reg [3];
    logic [7:0]       q_reg   [3];
    logic [SUM_W-1:0] trial;

    assign trial = SUM_W'(count) << bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (bit_reg == 3'd0);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == 3'd0) begin
                busy_reg <= 1'b0;
            end
        end
        if (start) begin
            bit_reg    <= 3'd7;
            rem_reg[0] <= sum_r;
            rem_reg[1] <= sum_g;
            rem_reg[2] <= sum_b;
            for (int i = 0; i < 3; i++) begin
                q_reg[i] <= 8'd0;
            end
        end else if (busy_reg) begin
            bit_reg <= bit_reg - 3'd1;
            for (int i = 0; i < 3; i++) begin
                if (rem_reg[i] >= trial) begin
                    rem_reg[i]         <= rem_reg[i] - trial;
                    q_reg[i][bit_reg] <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign mean = {q_reg[2], q_reg[1], q_reg[0]};
endmodule

>>> rtl/kmeans_color_quantizer.sv
// ----------------------------------------------------------------------------
// kmeans_color_quantizer
// Stores pixels and seeds, runs Lloyd passes, emits the final centroids.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// s_        in         tdata pixel colour, tuser seed flag, tlast start
// m_        out        tdata colour and index, tlast final centroid
// cfg_      in         cfg_index register, cfg_data value
//
// Loading accepts one word per cycle while idle. A pass sends every pixel
// through the distance pipeline once per cluster in use, then runs the
// divider for each cluster that holds any pixels. Input is refused
// from the start word until the last centroid has been loaded for output.
// Reset is synchronous; the pixel store needs no clearing.
// ----------------------------------------------------------------------------
module kmeans_color_quantizer #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_COLORS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_color
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // last_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // centroid_color, centroid_index, zero pad
    output logic        m_tlast,   // last_color
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import kmcq_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SUM_W  = CNT_W + 8;
    localparam int NC_W   = $clog2(MAX_COLORS + 1);
    localparam int CI_W   = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;

    state_t state_reg, state_next;

    logic [3:0]        num_colors_reg;
    logic [6:0]        max_passes_reg;
    logic [CNT_W-1:0]  pix_cnt_reg, p_reg;
    logic [NC_W-1:0]   seed_cnt_reg, n_reg;
    logic [CI_W-1:0]   c_reg, best_reg;
    logic [COLOR_W-1:0] cent_reg [MAX_COLORS];
    logic [SUM_W-1:0]  sum_r_reg [MAX_COLORS];
    logic [SUM_W-1:0]  sum_g_reg [MAX_COLORS];
    logic [SUM_W-1:0]  sum_b_reg [MAX_COLORS];
    logic [CNT_W-1:0]  cnt_reg   [MAX_COLORS];
    logic [COLOR_W-1:0] px_reg, nc_reg;
    logic [DIST_W-1:0] bestd_reg, move_reg;
    logic [6:0]        pass_reg;
    logic              m_valid_reg, m_last_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic [2:0]        m_index_reg;

    logic               s_fire, start_run, pix_full, c_last, p_last, out_free;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [COLOR_W-1:0] ram_rdata;
    logic               d_in_valid, d_out_valid;
    logic [COLOR_W-1:0] d_in_a;
    dist_tag_t          d_in_tag, d_out_tag;
    logic [DIST_W-1:0]  d_out;
    logic               div_start, div_done;
    logic [COLOR_W-1:0] div_mean;
    logic [CI_W-1:0]    best_fin;
    logic [NC_W-1:0]    n_clamp;
    logic [7:0]         pass_inc;
    logic [6:0]         pass_limit;

    assign s_fire    = s_tvalid && s_tready;
    assign start_run = s_fire && s_tlast;
    assign pix_full  = (pix_cnt_reg == CNT_W'(MAX_PIXELS));
    assign c_last    = ((NC_W'(c_reg) + NC_W'(1)) == n_reg);
    assign p_last    = ((p_reg + CNT_W'(1)) == pix_cnt_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign pass_inc  = {1'b0, pass_reg} + 8'd1;
    assign pass_limit = (max_passes_reg == 7'd0) ? 7'd1 : max_passes_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (num_colors_reg == 4'd0) begin
            n_clamp = NC_W'(1);
        end else if ({4'd0, num_colors_reg} > 8'(MAX_COLORS)) begin
            n_clamp = NC_W'(MAX_COLORS);
        end else begin
            n_clamp = NC_W'(num_colors_reg);
        end
    end

    assign best_fin = (d_out_tag.idx == 6'd0 || d_out < bestd_reg)
                    ? CI_W'(d_out_tag.idx) : best_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_run) begin
                    state_next = ST_PASS_CLR;
                end
            end
            ST_PASS_CLR: begin
                state_next = (pix_cnt_reg == '0) ? ST_UPD_START : ST_RD;
            end
            ST_RD:    state_next = ST_LATCH;
            ST_LATCH: state_next = ST_ISSUE;
            ST_ISSUE: begin
                if (c_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (d_out_valid && d_out_tag.last) begin
                    state_next = p_last ? ST_UPD_START : ST_RD;
                end
            end
            ST_UPD_START: begin
                state_next = (cnt_reg[c_reg] == '0) ? ST_MOVE : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE: state_next = ST_MOVE_WAIT;
            ST_MOVE_WAIT: begin
                if (d_out_valid) begin
                    state_next = c_last ? ST_PASS_END : ST_UPD_START;
                end
            end
            ST_PASS_END: begin
                state_next = (pass_inc < {1'b0, pass_limit} && move_reg > MOVE_LIMIT)
                           ? ST_PASS_CLR : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && c_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = pix_cnt_reg[ADDR_W-1:0];
        d_in_valid = 1'b0;
        d_in_a     = px_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_we   = s_fire && !s_tuser && !pix_full;
            end
            ST_RD:        ram_addr = p_reg[ADDR_W-1:0];
            ST_ISSUE:     d_in_valid = 1'b1;
            ST_UPD_START: div_start = (cnt_reg[c_reg] != '0);
            ST_MOVE: begin
                d_in_valid = 1'b1;
                d_in_a     = nc_reg;
            end
            default: begin
            end
        endcase
    end

    assign d_in_tag.idx  = 6'(c_reg);
    assign d_in_tag.last = c_last;

    kmcq_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_PIXELS)
    ) u_pixels (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata),
        .rdata (ram_rdata)
    );

    kmcq_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_in_valid),
        .in_a      (d_in_a),
        .in_b      (cent_reg[c_reg]),
        .in_tag    (d_in_tag),
        .out_valid (d_out_valid),
        .out_dist  (d_out),
        .out_tag   (d_out_tag)
    );

    kmcq_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum_r   (sum_r_reg[c_reg]),
        .sum_g   (sum_g_reg[c_reg]),
        .sum_b   (sum_b_reg[c_reg]),
        .count   (cnt_reg[c_reg]),
        .done    (div_done),
        .mean    (div_mean)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_colors_reg <= 4'd8;
            max_passes_reg <= 7'd101;
            pix_cnt_reg    <= '0;
            seed_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_COLORS; i++) begin
                cent_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_NUM_COLORS) begin
                    num_colors_reg <= cfg_data[3:0];
                end else if (cfg_index == REG_MAX_PASSES) begin
                    max_passes_reg <= cfg_data[6:0];
                end
            end
            if (s_fire) begin
                if (s_tuser) begin
                    if (seed_cnt_reg < NC_W'(MAX_COLORS)) begin
                        cent_reg[seed_cnt_reg[CI_W-1:0]] <= s_tdata;
                        seed_cnt_reg <= seed_cnt_reg + NC_W'(1);
                    end
                end else if (!pix_full) begin
                    pix_cnt_reg <= pix_cnt_reg + CNT_W'(1);
                end
            end
            if (state_reg == ST_MOVE_WAIT && d_out_valid) begin
                cent_reg[c_reg] <= nc_reg;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
                if (c_last) begin
                    pix_cnt_reg  <= '0;
                    seed_cnt_reg <= '0;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (start_run) begin
            n_reg    <= n_clamp;
            pass_reg <= 7'd0;
        end

        unique case (state_reg)
            ST_PASS_CLR: begin
                for (int i = 0; i < MAX_COLORS; i++) begin
                    sum_r_reg[i] <= '0;
                    sum_g_reg[i] <= '0;
                    sum_b_reg[i] <= '0;
                    cnt_reg[i]   <= '0;
                end
                move_reg <= '0;
                p_reg    <= '0;
                c_reg    <= '0;
            end
            ST_LATCH: begin
                px_reg <= ram_rdata;
                c_reg  <= '0;
            end
            ST_ISSUE: begin
                if (!c_last) begin
                    c_reg <= c_reg + CI_W'(1);
                end
            end
            ST_WAIT: begin
                if (d_out_valid && d_out_tag.last) begin
                    p_reg <= p_reg + CI_W'(0) + CNT_W'(1);
                    if (p_last) begin
                        c_reg <= '0;
                    end
                end
            end
            ST_UPD_START: begin
                if (cnt_reg[c_reg] == '0) begin
                    nc_reg <= WHITE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    nc_reg <= div_mean;
                end
            end
            ST_MOVE_WAIT: begin
                if (d_out_valid) begin
                    if (d_out > move_reg) begin
                        move_reg <= d_out;
                    end
                    if (!c_last) begin
                        c_reg <= c_reg + CI_W'(1);
                    end
                end
            end
            ST_PASS_END: begin
                pass_reg <= pass_inc[6:0];
                c_reg    <= '0;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_color_reg <= {cent_reg[c_reg][7:0], cent_reg[c_reg][15:8],
                                    cent_reg[c_reg][23:16]};
                    m_index_reg <= 3'(c_reg);
                    m_last_reg  <= c_last;
                    if (!c_last) begin
                        c_reg <= c_reg + CI_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        if ((state_reg == ST_ISSUE || state_reg == ST_WAIT) && d_out_valid) begin
            best_reg  <= best_fin;
            bestd_reg <= (best_fin == CI_W'(d_out_tag.idx)) ? d_out : bestd_reg;
            if (d_out_tag.last) begin
                sum_r_reg[best_fin] <= sum_r_reg[best_fin] + SUM_W'(px_reg[7:0]);
                sum_g_reg[best_fin] <= sum_g_reg[best_fin] + SUM_W'(px_reg[15:8]);
                sum_b_reg[best_fin] <= sum_b_reg[best_fin] + SUM_W'(px_reg[23:16]);
                cnt_reg[best_fin]   <= cnt_reg[best_fin] + CNT_W'(1);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_index_reg, m_color_reg};
    assign m_tlast  = m_last_reg;
endmodule
